FILE: sv/fat_entry_locate_codec_assert.svh
// Assertion macros for the FAT entry locate and pack block.
`ifndef FAT_ENTRY_LOCATE_CODEC_ASSERT_SVH
`define FAT_ENTRY_LOCATE_CODEC_ASSERT_SVH

`ifndef SYNTHESIS

`define FECL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fecl assertion failed");

`define FECL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fecl assertion failed");

`else

`define FECL_ASSERT_IMPL(label, clk, rst, ante, cons)

`define FECL_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/fecl_pkg.sv
// Types and constants shared by the FAT entry locate and pack block.
package fecl_pkg;

   localparam int unsigned FECL_FIRST_CLUSTER = 2;

   // Entry width modes
   localparam logic [1:0] WIDTH_FAT12       = 2'd0;
   localparam logic [1:0] WIDTH_FAT16       = 2'd1;
   localparam logic [1:0] WIDTH_FAT32       = 2'd2;
   localparam logic [1:0] WIDTH_UNSUPPORTED = 2'd3;

   // Result error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_CLUSTER = 2'd1;
   localparam logic [1:0] ERR_WIDTH   = 2'd2;

   // Action codes
   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic [2:0] CSR_ENTRY_WIDTH_MODE      = 3'd0;
   localparam logic [2:0] CSR_RESERVED_SECTOR_COUNT = 3'd1;
   localparam logic [2:0] CSR_ACTIVE_TABLE_INDEX    = 3'd2;
   localparam logic [2:0] CSR_TABLE_SECTOR_COUNT    = 3'd3;
   localparam logic [2:0] CSR_SECTOR_SIZE_LOG2      = 3'd4;
   localparam logic [2:0] CSR_DATA_CLUSTER_COUNT    = 3'd5;

   typedef struct packed {
      logic        action;
      logic [27:0] cluster;
      logic [31:0] raw_bytes;
      logic [27:0] write_value;
   } fecl_req_type;

   typedef struct packed {
      logic [31:0] sector;
      logic [11:0] byte_offset;
      logic        straddles_sector;
      logic [27:0] read_value;
      logic [31:0] write_bytes;
      logic [31:0] write_bit_mask;
      logic [1:0]  error;
   } fecl_rsp_type;

endpackage

FILE: sv/fat_entry_locate_codec.sv
// Top level of the FAT12/16/32 table entry locate and pack block.
`include "fat_entry_locate_codec_assert.svh"

// A transaction is taken on every clock edge at which start is high; busy never rises, so one
// transaction may follow another in each cycle. Its result passes through the request register
// and the result register and is shown for exactly one cycle with rsp_valid high, and results
// keep the order of the requests. Between those two registers lies only the sector arithmetic
// and the entry pack and unpack logic, so the block sustains one transaction per cycle and has
// no way to be held off by the receiver. Configuration writes are always accepted and must only
// be made while no transaction is in flight.
module fat_entry_locate_codec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  fecl_pkg::fecl_req_type req_data,
   output logic                  rsp_valid,
   output fecl_pkg::fecl_rsp_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);
   import fecl_pkg::*;

   logic [1:0]  entry_width_mode_ff;
   logic [15:0] reserved_sector_count_ff;
   logic [1:0]  active_table_index_ff;
   logic [31:0] table_sector_count_ff;
   logic [3:0]  sector_size_log2_ff;
   logic [27:0] data_cluster_count_ff;

   logic         req_valid_ff;
   fecl_req_type req_ff;
   logic         rsp_valid_ff;
   fecl_rsp_type rsp_ff;
   fecl_rsp_type rsp_in;

   logic        accept;
   logic [28:0] cluster_ext;
   logic [28:0] cluster_limit;
   logic        cluster_bad;
   logic [29:0] byte_addr;
   logic [1:0]  shift_sel;
   logic [29:0] sector_index;
   logic [11:0] offset;
   logic [11:0] offset_last;
   logic [31:0] table_base;
   logic [11:0] fat12_val;
   logic [15:0] fat16_val;

   logic        rsp_error;
   logic        rsp_fields_clear;
   logic        rsp_straddle;
   logic        rsp_at_sector_end;
   logic        rsp_write;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_width_mode_ff      <= WIDTH_FAT16;
         reserved_sector_count_ff <= 16'd1;
         active_table_index_ff    <= 2'd0;
         table_sector_count_ff    <= 32'd1;
         sector_size_log2_ff      <= 4'd9;
         data_cluster_count_ff    <= 28'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENTRY_WIDTH_MODE:      entry_width_mode_ff      <= csr_wdata[1:0];
            CSR_RESERVED_SECTOR_COUNT: reserved_sector_count_ff <= csr_wdata[15:0];
            CSR_ACTIVE_TABLE_INDEX:    active_table_index_ff    <= csr_wdata[1:0];
            CSR_TABLE_SECTOR_COUNT:    table_sector_count_ff    <= csr_wdata;
            CSR_SECTOR_SIZE_LOG2:      sector_size_log2_ff      <= csr_wdata[3:0];
            CSR_DATA_CLUSTER_COUNT:    data_cluster_count_ff    <= csr_wdata[27:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   // Sector arithmetic: the byte address is the cluster times the entry size in bytes.
   always_comb begin
      cluster_ext   = {1'b0, req_ff.cluster};
      cluster_limit = {1'b0, data_cluster_count_ff} + 29'(FECL_FIRST_CLUSTER);
      cluster_bad   = (cluster_ext < 29'(FECL_FIRST_CLUSTER)) || (cluster_ext >= cluster_limit);

      case (entry_width_mode_ff)
         WIDTH_FAT12: byte_addr = {2'b00, req_ff.cluster} + {3'b000, req_ff.cluster[27:1]};
         WIDTH_FAT16: byte_addr = {1'b0, req_ff.cluster, 1'b0};
         default:     byte_addr = {req_ff.cluster, 2'b00};
      endcase

      // Sector sizes below 512 bytes are treated as 512, above 4096 as 4096.
      if (sector_size_log2_ff inside {[4'd0 : 4'd9]}) begin
         shift_sel = 2'd0;
      end else if (sector_size_log2_ff inside {[4'd12 : 4'd15]}) begin
         shift_sel = 2'd3;
      end else begin
         shift_sel = 2'(sector_size_log2_ff - 4'd9);
      end

      case (shift_sel)
         2'd0: begin
            sector_index = byte_addr >> 9;
            offset       = {3'b000, byte_addr[8:0]};
            offset_last  = 12'h1ff;
         end
         2'd1: begin
            sector_index = byte_addr >> 10;
            offset       = {2'b00, byte_addr[9:0]};
            offset_last  = 12'h3ff;
         end
         2'd2: begin
            sector_index = byte_addr >> 11;
            offset       = {1'b0, byte_addr[10:0]};
            offset_last  = 12'h7ff;
         end
         default: begin
            sector_index = byte_addr >> 12;
            offset       = byte_addr[11:0];
            offset_last  = 12'hfff;
         end
      endcase

      table_base = 32'(table_sector_count_ff * 32'(active_table_index_ff));

      fat12_val = req_ff.cluster[0] ? req_ff.raw_bytes[15:4] : req_ff.raw_bytes[11:0];
      fat16_val = req_ff.raw_bytes[15:0];

      rsp_in = '0;
      if (entry_width_mode_ff == WIDTH_UNSUPPORTED) begin
         rsp_in.error = ERR_WIDTH;
      end else if (cluster_bad) begin
         rsp_in.error = ERR_CLUSTER;
      end else begin
         rsp_in.error       = ERR_NONE;
         rsp_in.sector      = 32'({16'd0, reserved_sector_count_ff}) + table_base
                              + {2'b00, sector_index};
         rsp_in.byte_offset = offset;
         rsp_in.straddles_sector = (entry_width_mode_ff == WIDTH_FAT12) && (offset == offset_last);
         if (req_ff.action == ACTION_READ) begin
            case (entry_width_mode_ff)
               WIDTH_FAT12: begin
                  // End-of-chain marks are widened to the FAT32 range.
                  rsp_in.read_value = (fat12_val > 12'hff0) ? {16'hffff, fat12_val}
                                                              : {16'd0, fat12_val};
               end
               WIDTH_FAT16: begin
                  rsp_in.read_value = (fat16_val > 16'hfff0) ? {12'hfff, fat16_val}
                                                               : {12'd0, fat16_val};
               end
               default: rsp_in.read_value = req_ff.raw_bytes[27:0];
            endcase
         end else begin
            case (entry_width_mode_ff)
               WIDTH_FAT12: begin
                  if (req_ff.cluster[0]) begin
                     rsp_in.write_bytes    = {16'd0, req_ff.write_value[11:0], 4'd0};
                     rsp_in.write_bit_mask = 32'h0000_fff0;
                  end else begin
                     rsp_in.write_bytes    = {20'd0, req_ff.write_value[11:0]};
                     rsp_in.write_bit_mask = 32'h0000_0fff;
                  end
               end
               WIDTH_FAT16: begin
                  rsp_in.write_bytes    = {16'd0, req_ff.write_value[15:0]};
                  rsp_in.write_bit_mask = 32'h0000_ffff;
               end
               default: begin
                  // The full mask clears the reserved top nibble of the stored entry.
                  rsp_in.write_bytes    = {4'd0, req_ff.write_value};
                  rsp_in.write_bit_mask = 32'hffff_ffff;
               end
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rsp_error         = rsp_valid && (rsp_data.error != ERR_NONE);
   assign rsp_fields_clear  = (rsp_data.sector == '0) && (rsp_data.read_value == '0)
                              && (rsp_data.write_bit_mask == '0);
   assign rsp_straddle      = rsp_valid && rsp_data.straddles_sector;
   assign rsp_at_sector_end = (rsp_data.error == ERR_NONE) && (rsp_data.byte_offset[8:0] == 9'h1ff);
   assign rsp_write         = rsp_valid && (rsp_data.write_bit_mask != '0);

   `FECL_ASSERT_IMPL(a_latency, clock, reset, start && !busy, ##2 rsp_valid)
   `FECL_ASSERT_IMPL(a_error_clears, clock, reset, rsp_error, rsp_fields_clear)
   `FECL_ASSERT_IMPL(a_straddle_at_end, clock, reset, rsp_straddle, rsp_at_sector_end)
   `FECL_ASSERT_IMPL(a_write_no_read, clock, reset, rsp_write, rsp_data.read_value == '0)

endmodule
